>>> design/sled_pkg.sv
// Shared types and constants of the string literal escape decoder.
package sled_pkg;

  // Decoder mode between input words
  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_ESC   = 2'd1,
    MODE_OCT   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_BYTE  = 2'd0,
    ST_CLOSE = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  // One queued entry: the one or two results that one input word causes
  typedef struct packed {
    logic       two;
    logic [7:0] byte0;
    status_t    status0;
    logic [7:0] byte1;
    status_t    status1;
  } entry_t;

endpackage

>>> design/sled_front.sv
// Front end: accepts body bytes, runs the escape state machine, builds result entries.
module sled_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       in_byte,
  output logic             q_push,
  output sled_pkg::entry_t q_entry
);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_QM    = 8'h3f;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_LBRC  = 8'h7b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6e;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SEVEN = 8'h37;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] ESC_CODE = 8'h1b;
  localparam logic [1:0] OCT_MAX  = 2'd3;

  typedef struct packed {
    logic                 has;
    logic [7:0]           val;
    sled_pkg::status_t    status;
    logic                 to_esc;
  } plain_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  sled_pkg::mode_t mode, mode_next;
  logic [7:0]      accum, accum_next;
  logic [1:0]      digit_count, digit_count_next;

  // Classify a byte seen in plain body mode
  function automatic plain_t plain_byte(input logic [7:0] c);
    plain_t r;
    r.has    = 1'b1;
    r.val    = c;
    r.status = sled_pkg::ST_BYTE;
    r.to_esc = 1'b0;
    if (c == CH_NUL) begin
      r.val    = 8'd0;
      r.status = sled_pkg::ST_ERROR;
    end else if (c == CH_DQ) begin
      r.val    = 8'd0;
      r.status = sled_pkg::ST_CLOSE;
    end else if (c == CH_BSL) begin
      r.has    = 1'b0;
      r.to_esc = 1'b1;
    end
    return r;
  endfunction

  // Decode one hex digit
  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t  r;
    logic [7:0] d;
    r.ok  = 1'b1;
    d     = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
    end else if (c >= CH_A && c <= CH_F) begin
      d = c - CH_A + 8'd10;
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
    end else begin
      r.ok = 1'b0;
    end
    r.val = d[3:0];
    return r;
  endfunction

  plain_t     pl;
  hex_t       hx;
  logic       is_oct;
  logic [1:0] dc_inc;
  logic [7:0] oct_acc;

  always_comb begin
    pl      = plain_byte(in_byte);
    hx      = hex_digit(in_byte);
    is_oct  = (in_byte >= CH_ZERO) && (in_byte <= CH_SEVEN);
    dc_inc  = digit_count + 2'd1;
    oct_acc = {accum[4:0], in_byte[2:0]};

    mode_next        = mode;
    accum_next       = accum;
    digit_count_next = digit_count;
    q_push           = 1'b0;
    q_entry.two      = 1'b0;
    q_entry.byte0    = 8'd0;
    q_entry.status0  = sled_pkg::ST_BYTE;
    q_entry.byte1    = 8'd0;
    q_entry.status1  = sled_pkg::ST_BYTE;

    unique case (mode) inside
      sled_pkg::MODE_PLAIN: begin
        q_push          = pl.has;
        q_entry.byte0   = pl.val;
        q_entry.status0 = pl.status;
        if (pl.to_esc) begin
          mode_next = sled_pkg::MODE_ESC;
        end
      end
      sled_pkg::MODE_ESC: begin
        // simple escapes finish here; octal digits and x open a numeric escape
        mode_next        = sled_pkg::MODE_PLAIN;
        accum_next       = 8'd0;
        digit_count_next = 2'd0;
        q_push           = 1'b1;
        unique case (in_byte) inside
          CH_SQ, CH_DQ, CH_QM, CH_BSL, CH_SLASH, CH_LPAR, CH_LBRC, CH_LBRK, CH_PCT:
            q_entry.byte0 = in_byte;
          CH_A: q_entry.byte0 = 8'd7;
          CH_B: q_entry.byte0 = 8'd8;
          CH_F: q_entry.byte0 = 8'd12;
          CH_N: q_entry.byte0 = 8'd10;
          CH_R: q_entry.byte0 = 8'd13;
          CH_T: q_entry.byte0 = 8'd9;
          CH_V: q_entry.byte0 = 8'd11;
          CH_E: q_entry.byte0 = ESC_CODE;
          [CH_ZERO:CH_SEVEN]: begin
            q_push           = 1'b0;
            mode_next        = sled_pkg::MODE_OCT;
            accum_next       = {5'd0, in_byte[2:0]};
            digit_count_next = 2'd1;
          end
          CH_X: begin
            q_push    = 1'b0;
            mode_next = sled_pkg::MODE_HEX;
          end
          default: q_entry.status0 = sled_pkg::ST_ERROR;
        endcase
      end
      sled_pkg::MODE_OCT, sled_pkg::MODE_HEX: begin
        if ((mode == sled_pkg::MODE_OCT) && is_oct) begin
          // take another octal digit; emit on the third
          accum_next       = oct_acc;
          digit_count_next = dc_inc;
          if (dc_inc == OCT_MAX || dc_inc == 2'd0) begin
            q_push           = 1'b1;
            q_entry.byte0    = oct_acc;
            mode_next        = sled_pkg::MODE_PLAIN;
            accum_next       = 8'd0;
            digit_count_next = 2'd0;
          end
        end else if ((mode == sled_pkg::MODE_HEX) && hx.ok) begin
          accum_next = {accum[3:0], hx.val};
        end else begin
          // emit the escape value, then treat the byte as plain
          q_push           = 1'b1;
          q_entry.byte0    = accum;
          q_entry.two      = pl.has;
          q_entry.byte1    = pl.val;
          q_entry.status1  = pl.status;
          mode_next        = pl.to_esc ? sled_pkg::MODE_ESC : sled_pkg::MODE_PLAIN;
          accum_next       = 8'd0;
          digit_count_next = 2'd0;
        end
      end
      default: mode_next = sled_pkg::MODE_PLAIN;
    endcase

    if (!accept) begin
      q_push           = 1'b0;
      mode_next        = mode;
      accum_next       = accum;
      digit_count_next = digit_count;
    end
  end

  // Hold decoder state between words
  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= sled_pkg::MODE_PLAIN;
      accum       <= 8'd0;
      digit_count <= 2'd0;
    end else begin
      mode        <= mode_next;
      accum       <= accum_next;
      digit_count <= digit_count_next;
    end
  end

endmodule

>>> design/sled_queue.sv
// Short queue of result entries between the front end and the back end.
module sled_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  sled_pkg::entry_t wr_data,
  input  logic             rd,
  output sled_pkg::entry_t rd_data,
  output logic             full,
  output logic             nonempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  sled_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]    head, tail;
  logic [CW-1:0]    count;

  assign full     = (count == FULL_CNT);
  assign nonempty = (count != '0);
  assign rd_data  = slots[head];

  // Store the incoming entry at the tail
  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= wr_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        tail <= (tail == LAST_SLOT) ? '0 : tail + PW'(1);
      end
      if (rd) begin
        head <= (head == LAST_SLOT) ? '0 : head + PW'(1);
      end
      if (wr && !rd) begin
        count <= count + CW'(1);
      end else if (rd && !wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

>>> design/sled_back.sv
// Back end: unpacks queued entries into single result words, one per cycle while words are popped.
module sled_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_nonempty,
  input  sled_pkg::entry_t q_data,
  output logic             q_pop,
  input  logic             pop,
  output logic             empty,
  output logic [7:0]       out_byte,
  output logic [1:0]       status,
  output logic             last
);

  sled_pkg::entry_t cur;
  logic             cur_valid;
  logic             idx;
  logic             final_word;
  logic             done;

  assign final_word = idx || !cur.two;
  assign done       = !cur_valid || (pop && final_word);
  assign q_pop      = q_nonempty && done;

  assign empty    = !cur_valid;
  assign out_byte = idx ? cur.byte1 : cur.byte0;
  assign status   = idx ? cur.status1 : cur.status0;
  assign last     = final_word;

  // Load the next entry once the current one is drained
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_data;
    end
  end

  // Step through the words of the current entry
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 1'b0;
    end else if (done) begin
      cur_valid <= q_nonempty;
      idx       <= 1'b0;
    end else if (pop) begin
      idx <= 1'b1;
    end
  end

endmodule

>>> design/string_literal_escape_decoder.sv
// Top level of the string literal escape decoder.
//
// Input channel: one body byte per word on in_byte, taken when push is high
// and full is low. Output channel: decoded words on out_byte, status and last,
// shown while empty is low and taken when pop is high.
// status 0 carries a decoded byte, 1 marks the closing quote, 2 an error
// (end of text or an unknown escape); last marks the final word of an input.
// A byte may give no word (backslash, x, a pending escape digit), one word, or
// two (a numeric escape ended by a byte that is not its digit or a backslash).
// A taken input's entry is written into the entry queue and then loaded into
// the back end's current-entry register, where its word is shown.
// The decoder takes one input byte per cycle while the output is popped each cycle;
// the back end delivers one word per cycle, so inputs that give two words
// hold the output longer, which the entry queue (QUEUE_DEPTH entries) absorbs.
// When the receiver stalls, the queue fills and full rises; no word is lost.
// Synchronous reset returns the decoder to plain body mode and empties the
// queue and the output stage. After a close or an error the decoder is back in
// plain body mode, ready for the next body.
module string_literal_escape_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       push,
  output logic       full,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       last,
  output logic       empty,
  input  logic       pop
);

  sled_pkg::entry_t f_entry;
  sled_pkg::entry_t q_data;
  logic             f_push;
  logic             q_pop;
  logic             q_nonempty;
  logic             accept;

  assign accept = push && !full;

  // Decode incoming bytes
  sled_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_byte),
    .q_push  (f_push),
    .q_entry (f_entry)
  );

  // Buffer entries between front and back
  sled_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (f_push),
    .wr_data  (f_entry),
    .rd       (q_pop),
    .rd_data  (q_data),
    .full     (full),
    .nonempty (q_nonempty)
  );

  // Deliver result words
  sled_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .out_byte   (out_byte),
    .status     (status),
    .last       (last)
  );

endmodule
